@@ rtl/core/mrr_pkg.sv @@
package mrr_pkg;
    localparam int CAND_W = 63;
    localparam int WORD_W = 32;
endpackage

@@ rtl/core/mrr_if.sv @@
interface mrr_req_if
    import mrr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CAND_W-1:0]   candidate;
    logic [WORD_W-1:0]   random_word;
    modport source (output valid, candidate, random_word, input ready);
    modport sink   (input valid, candidate, random_word, output ready);
endinterface

interface mrr_rsp_if;
    logic valid;
    logic ready;
    logic composite;
    modport source (output valid, composite, input ready);
    modport sink   (input valid, composite, output ready);
endinterface

@@ rtl/core/miller_rabin_round_top.sv @@
// One Miller-Rabin round on a NUM_BITS-bit odd candidate: the base is
// (random_word mod (n-1)) + 1, x = base^u mod n with n-1 = u*2^t, then the
// squaring chain is checked. The result is 1 when the candidate is proven
// composite, 0 when it is probably prime; 2 gives 0, 0, 1 and even numbers
// give 1. One item at a time: the request side is ready only while the block
// is idle. The work runs as a restoring reduction for the base, stripping of
// factors of two, and modular products on one shared shift-add multiplier;
// a round needs up to about 2*NUM_BITS products. A finished result waits in
// the output register while the next item is taken.
module miller_rabin_round_top
    import mrr_pkg::*;
#(
    parameter int NUM_BITS = 63
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrr_req_if.sink   i_req,
    mrr_rsp_if.source o_rsp
);
    localparam int W  = NUM_BITS;
    localparam int CW = $clog2(W);
    localparam int TW = $clog2(W + 1);
    localparam int DW = $clog2(WORD_W);
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};
    localparam logic [W-1:0] TWO = {{(W-2){1'b0}}, 2'b10};

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_FAC, S_PW, S_PSQ, S_MUL, S_WIT0, S_WLOOP, S_DONE
    } t_state;
    typedef enum logic [1:0] {OP_ACC, OP_SQ, OP_WIT} t_op;

    t_state           r_state;
    t_op              r_op;
    logic [W-1:0]     r_n, r_nm1, r_rem, r_u, r_acc, r_base, r_ma, r_mb, r_mr;
    logic [WORD_W-1:0] r_w;
    logic [DW-1:0]    r_dcnt;
    logic [CW-1:0]    r_mcnt;
    logic [TW-1:0]    r_t;
    logic             r_comp, r_ov, r_oc;

    logic [W-1:0]     n_in;
    logic [W:0]       m_t1, m_t1r, m_t2, m_t2r, d_t1, d_t1r;
    logic [W-1:0]     m_next, d_next;

    assign n_in = i_req.candidate[W-1:0];
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.composite = r_oc;

    // shared shift-add modular multiplier step
    always_comb begin
        m_t1  = {r_mr, 1'b0};
        m_t1r = (m_t1 >= {1'b0, r_n}) ? m_t1 - {1'b0, r_n} : m_t1;
        m_t2  = m_t1r + (r_mb[r_mcnt] ? {1'b0, r_ma} : '0);
        m_t2r = (m_t2 >= {1'b0, r_n}) ? m_t2 - {1'b0, r_n} : m_t2;
        m_next = m_t2r[W-1:0];
        // restoring remainder step for the base
        d_t1  = {r_rem, r_w[WORD_W-1]};
        d_t1r = (d_t1 >= {1'b0, r_nm1}) ? d_t1 - {1'b0, r_nm1} : d_t1;
        d_next = d_t1r[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (o_rsp.ready && r_state != S_DONE) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_n    <= n_in;
                        r_nm1  <= n_in - ONE;
                        r_u    <= n_in - ONE;
                        r_w    <= i_req.random_word;
                        r_rem  <= '0;
                        r_dcnt <= '0;
                        r_t    <= '0;
                        r_acc  <= ONE;
                        if (n_in == TWO) begin
                            r_comp  <= 1'b0;
                            r_state <= S_DONE;
                        end else if (n_in < TWO || !n_in[0]) begin
                            r_comp  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= d_next;
                    r_w    <= {r_w[WORD_W-2:0], 1'b0};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DW'(WORD_W - 1)) begin
                        r_base  <= d_next + ONE;
                        r_state <= S_FAC;
                    end
                end
                S_FAC: begin
                    if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                        r_t <= r_t + 1'b1;
                    end else begin
                        r_state <= S_PW;
                    end
                end
                S_PW: begin
                    if (r_u == '0) begin
                        r_state <= S_WIT0;
                    end else if (r_u[0]) begin
                        r_ma <= r_acc; r_mb <= r_base; r_mr <= '0;
                        r_mcnt <= CW'(W - 1); r_op <= OP_ACC;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_PSQ;
                    end
                end
                S_PSQ: begin
                    r_u <= r_u >> 1;
                    if (r_u[W-1:1] != '0) begin
                        r_ma <= r_base; r_mb <= r_base; r_mr <= '0;
                        r_mcnt <= CW'(W - 1); r_op <= OP_SQ;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_PW;
                    end
                end
                S_MUL: begin
                    r_mr   <= m_next;
                    r_mcnt <= r_mcnt - 1'b1;
                    if (r_mcnt == '0) begin
                        case (r_op)
                            OP_ACC: begin
                                r_acc <= m_next;
                                r_state <= S_PSQ;
                            end
                            OP_SQ: begin
                                r_base <= m_next;
                                r_state <= S_PW;
                            end
                            default: begin
                                if (r_acc != r_nm1 && r_acc != ONE && m_next == ONE) begin
                                    r_comp  <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_acc   <= m_next;
                                    r_t     <= r_t - 1'b1;
                                    r_state <= S_WLOOP;
                                end
                            end
                        endcase
                    end
                end
                S_WIT0: begin
                    if (r_acc == ONE) begin
                        r_comp  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WLOOP;
                    end
                end
                S_WLOOP: begin
                    if (r_t == '0) begin
                        r_comp  <= (r_acc != ONE);
                        r_state <= S_DONE;
                    end else begin
                        r_ma <= r_acc; r_mb <= r_acc; r_mr <= '0;
                        r_mcnt <= CW'(W - 1); r_op <= OP_WIT;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov    <= 1'b1;
                        r_oc    <= r_comp;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while busy");
    a_mul_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_mr < r_n && r_ma < r_n))
        else $error("multiplier operand not reduced");
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_nm1))
        else $error("base remainder out of range");
endmodule
